@@ rtl/core/tts_pkg.sv @@
// Shared constants, register map and sine table entry function for the two-tone generator.
package tts_pkg;

  localparam int DefPhaseBits   = 32;
  localparam int DefTableAddrBits = 10;

  localparam int CfgW       = 32;
  localparam int CfgIdxW    = 3;
  localparam int GainW      = 16;
  localparam int IdxW       = 16;
  localparam int SampleW    = 16;
  localparam int MixW       = 17;
  localparam int TabW       = 16;

  localparam logic [GainW-1:0] GainAReset = 16'd32768;
  localparam logic [GainW-1:0] GainBReset = 16'd16384;
  localparam logic [IdxW-1:0]  RunLenReset = 16'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TONE_A_STEP   = 3'd0,
    REG_TONE_A_OFFSET = 3'd1,
    REG_TONE_A_GAIN   = 3'd2,
    REG_TONE_B_STEP   = 3'd3,
    REG_TONE_B_OFFSET = 3'd4,
    REG_TONE_B_GAIN   = 3'd5,
    REG_RUN_LENGTH    = 3'd6
  } cfg_reg_e;

  localparam logic [63:0] Q30One    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Quarter-wave entry: odd Taylor series to x^15, Horner form, computed in Q30, returned as unsigned Q1.15.
  function automatic logic [TabW-1:0] sine_entry(input int unsigned k,
                                                 input int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] y;
    x = (HalfPiQ30 * 64'(k) + ((64'd1 << abits) >> 1)) >> abits;
    x2 = (x * x) >> 30;
    r = Q30One;
    term = ((x2 * r) >> 30) / 64'd210;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    term = ((x2 * r) >> 30) / 64'd156;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    term = ((x2 * r) >> 30) / 64'd110;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    term = ((x2 * r) >> 30) / 64'd72;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    term = ((x2 * r) >> 30) / 64'd42;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    term = ((x2 * r) >> 30) / 64'd20;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    term = ((x2 * r) >> 30) / 64'd6;
    r = (term >= Q30One) ? 64'd0 : Q30One - term;
    y = (((x * r) >> 30) + 64'd16384) >> 15;
    return y[TabW-1:0];
  endfunction

endpackage

@@ rtl/core/two_tone_sine_generator_core.sv @@
// Two-tone sine generator: three-stage phase, ROM and scale pipeline with config registers.
// Result path: phase registers, then ROM read registers, then scale/sum output registers.
// Throughput: one item per cycle while the output is not stalled; each stage does one phase add, ROM read or multiply.
// Input stalls only while all three stages hold items and the output is stalled.
// Reset: clears index, accumulators and stage valids; config returns to its defaults.
// The sine ROM is constant and needs no clearing pass.
module two_tone_sine_generator_core import tts_pkg::*; #(
  parameter int PHASE_BITS      = DefPhaseBits,
  parameter int TABLE_ADDR_BITS = DefTableAddrBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      restart_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] tone_a_sample_o,
  output logic signed [SampleW-1:0] tone_b_sample_o,
  output logic signed [MixW-1:0]    mixed_sample_o,
  output logic                      last_of_run_o
);

  localparam int TW = TABLE_ADDR_BITS + 2;

  logic [CfgW-1:0]  step_a_q, off_a_q, step_b_q, off_b_q;
  logic [GainW-1:0] gain_a_q, gain_b_q;
  logic [IdxW-1:0]  run_len_q;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3, accept;

  logic [TW-1:0]            top_a, top_b;
  logic                     last1;
  logic                     last2_q;
  logic [TabW-1:0]          tab_a, tab_b;
  logic                     neg_a, neg_b;
  logic signed [SampleW-1:0] samp_a, samp_b;

  logic signed [SampleW-1:0] a_q, b_q;
  logic signed [MixW-1:0]    mix_q;
  logic                      last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_a_q  <= '0;
      off_a_q   <= '0;
      gain_a_q  <= GainAReset;
      step_b_q  <= '0;
      off_b_q   <= '0;
      gain_b_q  <= GainBReset;
      run_len_q <= RunLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TONE_A_STEP:   step_a_q  <= cfg_data_i;
        REG_TONE_A_OFFSET: off_a_q   <= cfg_data_i;
        REG_TONE_A_GAIN:   gain_a_q  <= cfg_data_i[GainW-1:0];
        REG_TONE_B_STEP:   step_b_q  <= cfg_data_i;
        REG_TONE_B_OFFSET: off_b_q   <= cfg_data_i;
        REG_TONE_B_GAIN:   gain_b_q  <= cfg_data_i[GainW-1:0];
        REG_RUN_LENGTH:    run_len_q <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: each stage loads when it is empty or its successor moves
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign accept     = in_valid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  tts_phase #(
    .PHASE_BITS     (PHASE_BITS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .restart_i   (restart_i),
    .step_a_i    (step_a_q),
    .offset_a_i  (off_a_q),
    .step_b_i    (step_b_q),
    .offset_b_i  (off_b_q),
    .run_length_i(run_len_q),
    .top_a_o     (top_a),
    .top_b_o     (top_b),
    .last_o      (last1)
  );

  tts_lookup #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_lookup_a (
    .clk_i(clk_i),
    .en_i (rdy2),
    .top_i(top_a),
    .tab_o(tab_a),
    .neg_o(neg_a)
  );

  tts_lookup #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_lookup_b (
    .clk_i(clk_i),
    .en_i (rdy2),
    .top_i(top_b),
    .tab_o(tab_b),
    .neg_o(neg_b)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) last2_q <= last1;
  end

  tts_scale u_scale_a (
    .tab_i   (tab_a),
    .neg_i   (neg_a),
    .gain_i  (gain_a_q),
    .sample_o(samp_a)
  );

  tts_scale u_scale_b (
    .tab_i   (tab_b),
    .neg_i   (neg_b),
    .gain_i  (gain_b_q),
    .sample_o(samp_b)
  );

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      a_q     <= samp_a;
      b_q     <= samp_b;
      mix_q   <= MixW'(samp_a) + MixW'(samp_b);
      last3_q <= last2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign tone_a_sample_o = a_q;
  assign tone_b_sample_o = b_q;
  assign mixed_sample_o  = mix_q;
  assign last_of_run_o   = last3_q;

endmodule

@@ rtl/core/tts_phase.sv @@
// Sample index, run counter and phase accumulators; registers both tones' table phases.
module tts_phase import tts_pkg::*; #(
  parameter int PHASE_BITS      = DefPhaseBits,
  parameter int TABLE_ADDR_BITS = DefTableAddrBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       restart_i,
  input  logic [CfgW-1:0]            step_a_i,
  input  logic [CfgW-1:0]            offset_a_i,
  input  logic [CfgW-1:0]            step_b_i,
  input  logic [CfgW-1:0]            offset_b_i,
  input  logic [IdxW-1:0]            run_length_i,
  output logic [TABLE_ADDR_BITS+1:0] top_a_o,
  output logic [TABLE_ADDR_BITS+1:0] top_b_o,
  output logic                       last_o
);

  localparam int P   = PHASE_BITS;
  localparam int TW  = TABLE_ADDR_BITS + 2;
  localparam int Shl = (P >= CfgW) ? P - CfgW : 0;
  localparam int Shr = (P >= CfgW) ? 0 : CfgW - P;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [P-1:0]    acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic [TW-1:0]   top_a_q, top_b_q;
  logic            last_q, last_d;

  logic [IdxW-1:0] base_idx;
  logic [P-1:0]    base_a, base_b;
  logic [P-1:0]    w_off_a, w_off_b, w_step_a, w_step_b;
  logic [P-1:0]    phase_a, phase_b;
  logic [IdxW:0]   run_len;

  always_comb begin
    w_off_a  = P'(offset_a_i >> Shr) << Shl;
    w_off_b  = P'(offset_b_i >> Shr) << Shl;
    w_step_a = P'(step_a_i >> Shr) << Shl;
    w_step_b = P'(step_b_i >> Shr) << Shl;

    base_idx = restart_i ? '0 : idx_q;
    base_a   = restart_i ? '0 : acc_a_q;
    base_b   = restart_i ? '0 : acc_b_q;

    phase_a = w_off_a + base_a;
    phase_b = w_off_b + base_b;

    run_len = (run_length_i == '0) ? (IdxW+1)'(1) << IdxW : {1'b0, run_length_i};
    last_d  = ({1'b0, base_idx} + (IdxW+1)'(1)) >= run_len;

    if (last_d) begin
      idx_d   = '0;
      acc_a_d = '0;
      acc_b_d = '0;
    end else begin
      idx_d   = base_idx + IdxW'(1);
      acc_a_d = base_a + w_step_a;
      acc_b_d = base_b + w_step_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (accept_i) begin
      idx_q   <= idx_d;
      acc_a_q <= acc_a_d;
      acc_b_q <= acc_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      top_a_q <= phase_a[P-1 -: TW];
      top_b_q <= phase_b[P-1 -: TW];
      last_q  <= last_d;
    end
  end

  assign top_a_o = top_a_q;
  assign top_b_o = top_b_q;
  assign last_o  = last_q;

endmodule

@@ rtl/core/tts_lookup.sv @@
// Quadrant folding and registered quarter-wave sine ROM read for one tone.
module tts_lookup import tts_pkg::*; #(
  parameter int TABLE_ADDR_BITS = DefTableAddrBits
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [TABLE_ADDR_BITS+1:0] top_i,
  output logic [TabW-1:0]            tab_o,
  output logic                       neg_o
);

  localparam int A     = TABLE_ADDR_BITS;
  localparam int Depth = (1 << A) + 1;

  typedef logic [TabW-1:0] sine_tab_t [Depth];

  function automatic sine_tab_t build_tab();
    sine_tab_t t;
    for (int k = 0; k < Depth; k++) begin
      t[k] = sine_entry(k, A);
    end
    return t;
  endfunction

  localparam sine_tab_t SineTab = build_tab();

  logic [A-1:0]    k;
  logic [A:0]      addr;
  logic [TabW-1:0] tab_q;
  logic            neg_q;

  always_comb begin
    k    = top_i[A-1:0];
    addr = top_i[A] ? ((A+1)'(1) << A) - {1'b0, k} : {1'b0, k};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tab_q <= SineTab[addr];
      neg_q <= top_i[A+1];
    end
  end

  assign tab_o = tab_q;
  assign neg_o = neg_q;

endmodule

@@ rtl/core/tts_scale.sv @@
// Gain multiply with rounding, sign and Q1.15 saturation for one tone.
module tts_scale import tts_pkg::*; (
  input  logic [TabW-1:0]           tab_i,
  input  logic                      neg_i,
  input  logic [GainW-1:0]          gain_i,
  output logic signed [SampleW-1:0] sample_o
);

  logic [TabW+GainW:0] sum;
  logic [17:0]         mag;

  always_comb begin
    sum = (TabW+GainW+1)'(tab_i) * (TabW+GainW+1)'(gain_i) + (TabW+GainW+1)'(16384);
    mag = sum[TabW+GainW:15];
    if (neg_i) begin
      sample_o = (mag > 18'd32768) ? 16'sh8000 : -$signed(mag[SampleW-1:0]);
    end else begin
      sample_o = (mag > 18'd32767) ? 16'sh7FFF : $signed(mag[SampleW-1:0]);
    end
  end

endmodule

@@ tb/tts_sample_checker.sv @@
// Checker for the two-tone generator: tracks config writes, predicts each sample, compares.
module tts_sample_checker import tts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               restart_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [SampleW-1:0] tone_a_sample_i,
  input  logic [SampleW-1:0] tone_b_sample_i,
  input  logic [MixW-1:0]    mixed_sample_i,
  input  logic               last_of_run_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          AddrBits = DefTableAddrBits;
  localparam int unsigned Quarter  = 1 << AddrBits;
  localparam logic [63:0] TurnQ30  = 64'd1 << 30;
  localparam logic [63:0] HalfPi   = 64'd1686629713;

  typedef struct packed {
    logic [SampleW-1:0] tone_a;
    logic [SampleW-1:0] tone_b;
    logic [MixW-1:0]    mixed;
    logic               last;
  } sample_t;

  int unsigned sine_lut [0:Quarter];
  sample_t     sample_q [$];
  int          err_cnt = 0;
  int          pend = 0;

  logic [31:0]      step_a, offs_a, step_b, offs_b;
  logic [GainW-1:0] gain_a, gain_b;
  logic [IdxW-1:0]  run_len;
  logic [IdxW-1:0]  idx;
  logic [31:0]      acc_a, acc_b;

  assign errors_o  = err_cnt;
  assign pending_o = pend;

  // Quarter-wave entry computed in Q30 and returned as Q1.15, odd series to x^15, truncating products.
  function automatic int unsigned quarter_wave(input int unsigned k);
    logic [63:0] x, x2, r, term;
    int unsigned d;
    x = (HalfPi * 64'(k) + 64'(Quarter >> 1)) >> AddrBits;
    x2 = (x * x) >> 30;
    r = TurnQ30;
    for (d = 14; d >= 2; d -= 2) begin
      term = ((x2 * r) >> 30) / 64'(d * (d + 1));
      r = (term >= TurnQ30) ? 64'd0 : TurnQ30 - term;
    end
    return int'((((x * r) >> 30) + 64'd16384) >> 15);
  endfunction

  function automatic int tone_level(input logic [31:0] phase, input logic [GainW-1:0] gain);
    logic [AddrBits+1:0] seg;
    int unsigned         k;
    logic [63:0]         y;
    seg = phase[31 -: AddrBits+2];
    k = seg[AddrBits-1:0];
    if (seg[AddrBits]) k = Quarter - k;
    y = (64'(sine_lut[k]) * 64'(gain) + 64'd16384) >> 15;
    if (seg[AddrBits+1]) return (y > 64'd32768) ? -32768 : -int'(y);
    return (y > 64'd32767) ? 32767 : int'(y);
  endfunction

  task automatic predict_sample(input logic rs, output sample_t s);
    int          a, b, m;
    int unsigned len;
    logic        fin;
    if (rs) begin
      idx = '0;
      acc_a = '0;
      acc_b = '0;
    end
    a = tone_level(offs_a + acc_a, gain_a);
    b = tone_level(offs_b + acc_b, gain_b);
    m = a + b;
    len = (run_len == 0) ? 65536 : run_len;
    fin = (32'(idx) + 1) >= len;
    s.tone_a = a[SampleW-1:0];
    s.tone_b = b[SampleW-1:0];
    s.mixed  = m[MixW-1:0];
    s.last   = fin;
    if (fin) begin
      idx = '0;
      acc_a = '0;
      acc_b = '0;
    end else begin
      idx = idx + 1'b1;
      acc_a = acc_a + step_a;
      acc_b = acc_b + step_b;
    end
  endtask

  initial begin
    for (int unsigned k = 0; k <= Quarter; k++) sine_lut[k] = quarter_wave(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin : track
    sample_t want, got;
    if (!rst_ni) begin
      step_a = '0;
      offs_a = '0;
      gain_a = GainAReset;
      step_b = '0;
      offs_b = '0;
      gain_b = GainBReset;
      run_len = RunLenReset;
      idx = '0;
      acc_a = '0;
      acc_b = '0;
      sample_q.delete();
      pend = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{tone_a_sample_i, tone_b_sample_i, mixed_sample_i, last_of_run_i};
        if (sample_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%t: unexpected sample a=%h b=%h mix=%h last=%b", $realtime,
                     got.tone_a, got.tone_b, got.mixed, got.last);
        end else begin
          want = sample_q.pop_front();
          if (want.tone_a !== got.tone_a || want.tone_b !== got.tone_b ||
              want.mixed !== got.mixed || want.last !== got.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%t: sample differs exp a=%h b=%h mix=%h last=%b, got a=%h b=%h mix=%h last=%b",
                       $realtime, want.tone_a, want.tone_b, want.mixed, want.last,
                       got.tone_a, got.tone_b, got.mixed, got.last);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TONE_A_STEP:   step_a = cfg_data_i;
          REG_TONE_A_OFFSET: offs_a = cfg_data_i;
          REG_TONE_A_GAIN:   gain_a = cfg_data_i[GainW-1:0];
          REG_TONE_B_STEP:   step_b = cfg_data_i;
          REG_TONE_B_OFFSET: offs_b = cfg_data_i;
          REG_TONE_B_GAIN:   gain_b = cfg_data_i[GainW-1:0];
          REG_RUN_LENGTH:    run_len = cfg_data_i[IdxW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_sample(restart_i, want);
        sample_q.push_back(want);
      end
      pend = sample_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the two-tone generator: clock, reset, stimulus, stalls and verdict.
module tb_top;
  import tts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare      = 3'd7;
  localparam int                 WatchdogLimit = 2000;
  localparam int                 RandomItems   = 1050;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_idx_i;
  logic [CfgW-1:0]           cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      restart_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] tone_a_sample_o;
  logic signed [SampleW-1:0] tone_b_sample_o;
  logic signed [MixW-1:0]    mixed_sample_o;
  logic                      last_of_run_o;

  int errors;
  int pending;
  bit idle_on = 1'b1;
  int out_hold = 0;
  int quiet_cycles = 0;
  int rand_sent = 0;

  always #5 clk_i = ~clk_i;

  two_tone_sine_generator_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .restart_i,
    .out_valid_o, .out_stall_i,
    .tone_a_sample_o, .tone_b_sample_o, .mixed_sample_o, .last_of_run_o
  );

  tts_sample_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .restart_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .tone_a_sample_i(tone_a_sample_o), .tone_b_sample_i(tone_b_sample_o),
    .mixed_sample_i(mixed_sample_o), .last_of_run_i(last_of_run_o),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver stall: a fresh random hold after every taken sample while idle_on is set, none otherwise.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) out_hold <= idle_on ? $urandom_range(0, 3) : 0;
    else if (out_hold != 0) out_hold <= out_hold - 1;
  end

  always @(negedge clk_i) out_stall_i <= (out_hold != 0);

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("two_tone_sine_generator_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_setting(input logic [31:0] a_step, a_offs, a_gain,
                              input logic [31:0] b_step, b_offs, b_gain, len);
    write_reg(REG_TONE_A_STEP, a_step);
    write_reg(REG_TONE_A_OFFSET, a_offs);
    write_reg(REG_TONE_A_GAIN, a_gain);
    write_reg(REG_TONE_B_STEP, b_step);
    write_reg(REG_TONE_B_OFFSET, b_offs);
    write_reg(REG_TONE_B_GAIN, b_gain);
    write_reg(REG_RUN_LENGTH, len);
  endtask

  task automatic send_tick(input logic rs);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= rs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'd32768;
      2: return $urandom;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'd65535;
      2: return 32'd1;
      3: return {v[31:16], 16'($urandom_range(1, 40))};
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  initial begin
    int n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults, zero phase
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // quadrant walk; gain above unity saturates both ways; run length zero
    load_setting(32'h4000_0000, 32'h0, 32'd32768,
                 32'hC000_0000, 32'h2000_0000, 32'hFFFF_FFFF, 32'h0);
    idle_on = 1'b0;
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    drain();

    // extreme offsets, zero gain, single-sample runs, write to an unused index
    load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h1);
    write_reg(RegSpare, 32'h0000_0005);
    idle_on = 1'b1;
    repeat (3) send_tick(1'b0);
    drain();

    // run length dropped below the current index
    load_setting(32'h0123_4567, 32'h3000_0000, 32'd20000,
                 32'h89AB_CDEF, 32'h7000_0000, 32'd30000, 32'hABCD_0014);
    send_tick(1'b1);
    repeat (9) send_tick(1'b0);
    drain();
    write_reg(REG_RUN_LENGTH, 32'h3);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    while (rand_sent < RandomItems) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 5) != 0)
        load_setting(pick_step(), pick_offset(), pick_gain(),
                     pick_step(), pick_offset(), pick_gain(), pick_len());
      else
        write_reg(REG_RUN_LENGTH, pick_len());
      if ($urandom_range(0, 7) == 0) write_reg(RegSpare, $urandom);
      n = $urandom_range(20, 80);
      if (n > RandomItems - rand_sent) n = RandomItems - rand_sent;
      for (int i = 0; i < n; i++) begin
        send_tick((i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 15) == 0);
        rand_sent++;
      end
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (errors == 0)
      $display("two_tone_sine_generator_core: match");
    else
      $display("two_tone_sine_generator_core: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tts_pkg.sv
rtl/core/tts_phase.sv
rtl/core/tts_lookup.sv
rtl/core/tts_scale.sv
rtl/core/two_tone_sine_generator_core.sv
tb/tts_sample_checker.sv
tb/tb_top.sv
